// ----- hw/rtl/b64_pkg.sv -----
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int         GROUP_RESULTS = 4;
  localparam int         CNT_W = $clog2(GROUP_RESULTS + 1);

  // Six-bit value to its character in the standard alphabet.
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Character to {not_in_alphabet, six-bit value}.
  function automatic logic [6:0] sym_val(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/base64_codec.sv -----
// Streaming Base64 codec with the standard alphabet. cfg_wr_data selects the direction
// (0 encodes bytes to text, 1 decodes text to bytes); writing it starts a new stream. Each
// input beat is worked out combinationally into a group of up to four result beats, which
// then drain through the output register one per cycle unless m_axis_tready stalls them.
// A new input beat is taken in the cycle that the last beat of the previous group moves
// to the output register, or whenever no result beat of a group is pending.
// s_axis_tlast flushes and pads the encoder, or drops partial decoder bits. An invalid
// character gives one beat with tuser set and tdata zero, and the rest of the stream up to
// tlast is then dropped.
module base64_codec
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] bad_symbol
);

  logic              dir;
  logic [1:0]        pos;
  logic [23:0]       acc;
  logic              disc;
  logic [1:0]        pos_next;
  logic [23:0]       acc_next;
  logic              disc_next;

  logic [7:0]        r_byte [GROUP_RESULTS];
  logic [CNT_W-1:0]  r_cnt;
  logic              r_bad;
  logic [23:0]       acc_enc;
  logic [23:0]       acc_dec;
  logic [6:0]        dv;

  logic [7:0]        g_byte [GROUP_RESULTS];
  logic [CNT_W-1:0]  g_cnt;
  logic              g_bad;

  logic              o_valid;
  logic [7:0]        o_data;
  logic              o_last;
  logic              o_bad;

  logic              accept;
  logic              move;

  assign s_axis_tready = (g_cnt == '0) || ((g_cnt == CNT_W'(1)) && move);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign move          = (g_cnt != '0) && (!o_valid || m_axis_tready);

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_bad;

  always_comb begin
    for (int i = 0; i < GROUP_RESULTS; i++) begin
      r_byte[i] = 8'h00;
    end
    r_cnt     = '0;
    r_bad     = 1'b0;
    pos_next  = pos;
    acc_next  = acc;
    disc_next = disc;
    acc_enc   = acc;
    acc_dec   = acc;
    dv        = sym_val(s_axis_tdata);

    if (disc) begin
      r_cnt = '0;
    end else if (!dir) begin
      case (pos)
        2'd1: begin
          acc_enc   = acc | {8'h00, s_axis_tdata, 8'h00};
          r_byte[0] = sym_char(acc_enc[17:12]);
          r_cnt     = CNT_W'(1);
          if (s_axis_tlast) begin
            r_byte[1] = sym_char(acc_enc[11:6]);
            r_byte[2] = PAD_CHAR;
            r_cnt     = CNT_W'(3);
          end
          acc_next = acc_enc;
          pos_next = 2'd2;
        end
        2'd2: begin
          acc_enc   = acc | {16'h0000, s_axis_tdata};
          r_byte[0] = sym_char(acc_enc[11:6]);
          r_byte[1] = sym_char(acc_enc[5:0]);
          r_cnt     = CNT_W'(2);
          acc_next  = '0;
          pos_next  = 2'd0;
        end
        default: begin
          acc_enc   = {s_axis_tdata, 16'h0000};
          r_byte[0] = sym_char(s_axis_tdata[7:2]);
          r_cnt     = CNT_W'(1);
          if (s_axis_tlast) begin
            r_byte[1] = sym_char({s_axis_tdata[1:0], 4'h0});
            r_byte[2] = PAD_CHAR;
            r_byte[3] = PAD_CHAR;
            r_cnt     = CNT_W'(4);
          end
          acc_next = acc_enc;
          pos_next = 2'd1;
        end
      endcase
    end else if (dv[6]) begin
      if (s_axis_tdata != PAD_CHAR) begin
        r_cnt     = CNT_W'(1);
        r_bad     = 1'b1;
        disc_next = 1'b1;
      end else if (pos == 2'd3) begin
        acc_next = '0;
        pos_next = 2'd0;
      end else begin
        pos_next = pos + 2'd1;
      end
    end else begin
      case (pos)
        2'd0:    acc_dec = acc | {dv[5:0], 18'h0};
        2'd1:    acc_dec = acc | {6'h0, dv[5:0], 12'h0};
        2'd2:    acc_dec = acc | {12'h0, dv[5:0], 6'h0};
        default: acc_dec = acc | {18'h0, dv[5:0]};
      endcase
      acc_next = acc_dec;
      case (pos)
        2'd1: begin
          r_byte[0] = acc_dec[23:16];
          r_cnt     = CNT_W'(1);
        end
        2'd2: begin
          r_byte[0] = acc_dec[15:8];
          r_cnt     = CNT_W'(1);
        end
        2'd3: begin
          r_byte[0] = acc_dec[7:0];
          r_cnt     = CNT_W'(1);
          acc_next  = '0;
        end
        default: r_cnt = '0;
      endcase
      pos_next = pos + 2'd1;
    end

    if (s_axis_tlast) begin
      pos_next  = 2'd0;
      acc_next  = '0;
      disc_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir     <= 1'b0;
      pos     <= 2'd0;
      acc     <= '0;
      disc    <= 1'b0;
      g_cnt   <= '0;
      o_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dir  <= cfg_wr_data;
        pos  <= 2'd0;
        acc  <= '0;
        disc <= 1'b0;
      end else if (accept) begin
        pos  <= pos_next;
        acc  <= acc_next;
        disc <= disc_next;
      end
      if (accept) begin
        g_cnt <= r_cnt;
      end else if (move) begin
        g_cnt <= g_cnt - CNT_W'(1);
      end
      if (move) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < GROUP_RESULTS; i++) begin
        g_byte[i] <= r_byte[i];
      end
      g_bad <= r_bad;
    end else if (move) begin
      for (int i = 0; i < GROUP_RESULTS - 1; i++) begin
        g_byte[i] <= g_byte[i+1];
      end
      g_byte[GROUP_RESULTS-1] <= 8'h00;
    end
    if (move) begin
      o_data <= g_byte[0];
      o_last <= (g_cnt == CNT_W'(1));
      o_bad  <= g_bad && (g_cnt == CNT_W'(1));
    end
  end

endmodule

// ----- hw/rtl/b64_checker.sv -----
module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_wr_en,
  input logic       cfg_wr_data,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // Nothing is offered on the output in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // An error beat stands alone, with zero data.
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
    else $error("error beat not alone or not zero");

  // The beats of one item follow each other without a gap.
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside the beats of one item");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule

bind base64_codec b64_checker u_b64_checker (.*);
